@@ hw/rtl/dat_pkg.sv @@
// Shared types and constants for the digest agreement tracker.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package dat_pkg;

	localparam int DEF_RING_DEPTH = 64;
	localparam int DEF_SEAT_COUNT = 8;
	localparam logic [31:0] TOP_TICK = 32'hffff_ffff;
	localparam int IN_BITS  = 80;
	localparam int OUT_BITS = 136;

	// configuration register indexes
	localparam logic REG_MODE = 1'b0;
	localparam logic REG_MASK = 1'b1;

	typedef enum logic [1:0] {
		OP_NOTE_LOCAL = 2'd0,
		OP_NOTE_PEER  = 2'd1,
		OP_PRIME      = 2'd2,
		OP_HEAL       = 2'd3
	} op_t;

	typedef struct packed {
		logic [31:0] digest;
		logic [31:0] tick;
		logic [7:0]  seat;
		op_t         op;
	} cmd_t;

	typedef struct packed {
		logic       multi;
		logic [7:0] mask;
	} cfg_t;

	typedef struct packed {
		logic [31:0] mismatch_peer;
		logic [31:0] mismatch_local;
		logic [2:0]  mismatch_seat;
		logic [31:0] mismatch_tick;
		logic        mismatch_found;
		logic [31:0] resolved_tick;
		logic        resolved_ok;
		logic        accepted;
	} res_t;

endpackage

`default_nettype wire

@@ hw/rtl/dat_front.sv @@
// Front end: accepts command items, decodes them and works out the ring index.
// Depends on dat_pkg.
`default_nettype none

module dat_front import dat_pkg::*; #(
	parameter int RING_DEPTH = DEF_RING_DEPTH,
	parameter int IW = $clog2(RING_DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire cmd_t          in_cmd,
	output logic               q_valid,
	input  wire logic          q_ready,
	output cmd_t               q_cmd,
	output logic [IW-1:0]      q_idx
);

	localparam bit IS_POW2 = (RING_DEPTH & (RING_DEPTH - 1)) == 0;
	// reciprocal of the ring depth scaled by 2^(32+IW), rounded up
	localparam logic [63:0] RECIP_WIDE =
		((64'd1 << (32 + IW)) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);
	localparam logic [32:0] RECIP = RECIP_WIDE[32:0];
	localparam logic [IW-1:0] DEPTH_LO = IW'(RING_DEPTH);

	typedef enum logic [1:0] {F_IDLE, F_MUL, F_SUB, F_PUSH} fstate_t;

	fstate_t       state_q;
	cmd_t          cmd_q;
	logic [64:0]   prod_q;
	logic [IW-1:0] rem_q;
	logic [IW-1:0] quo_lo, qd_lo;

	assign in_ready = (state_q == F_IDLE);
	assign q_valid  = (state_q == F_PUSH);
	assign q_cmd    = cmd_q;
	assign q_idx    = rem_q;

	// low quotient bits times depth, enough for the remainder
	assign quo_lo = prod_q[32+IW +: IW];
	assign qd_lo  = quo_lo * DEPTH_LO;

	// accept, reduce tick modulo ring depth, hand to queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						cmd_q <= in_cmd;
						if (IS_POW2) begin
							rem_q   <= in_cmd.tick[IW-1:0];
							state_q <= F_PUSH;
						end else begin
							state_q <= F_MUL;
						end
					end
				end
				F_MUL: begin
					prod_q  <= 65'(cmd_q.tick) * 65'(RECIP);
					state_q <= F_SUB;
				end
				F_SUB: begin
					rem_q   <= cmd_q.tick[IW-1:0] - qd_lo;
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (q_ready)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/dat_queue.sv @@
// Two-entry item queue between front and back parts.
// Depends on dat_pkg only for the house import.
`default_nettype none

module dat_queue import dat_pkg::*; #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_valid,
	output logic              wr_ready,
	input  wire logic [W-1:0] wr_data,
	output logic              rd_valid,
	input  wire logic         rd_ready,
	output logic [W-1:0]      rd_data
);

	logic [W-1:0] slot_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;
	logic         push, pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = slot_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// store payload
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wp_q] <= wr_data;
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/dat_back.sv @@
// Back end: executes commands on the local and seat rings, advances the
// resolved tick, heals gaps and holds the result register. Depends on dat_pkg.
`default_nettype none

module dat_back import dat_pkg::*; #(
	parameter int RING_DEPTH = DEF_RING_DEPTH,
	parameter int SEAT_COUNT = DEF_SEAT_COUNT,
	parameter int IW = $clog2(RING_DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cfg_t          cfg,
	input  wire logic          cmd_valid,
	output logic               cmd_ready,
	input  wire cmd_t          cmd_in,
	input  wire logic [IW-1:0] idx_in,
	output logic               out_valid,
	input  wire logic          out_ready,
	output res_t               out_res
);

	localparam int SW = (SEAT_COUNT > 1) ? $clog2(SEAT_COUNT) : 1;
	localparam int SN = 1 << SW;
	localparam logic [IW-1:0] LAST_ROW  = IW'(RING_DEPTH - 1);
	localparam logic [SW-1:0] LAST_SEAT = SW'(SEAT_COUNT - 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_EXEC, ST_PRD, ST_PWR, ST_ADV, ST_ROW, ST_ROWD,
		ST_SEATI, ST_SEATC, ST_ROWEND, ST_HNEXT, ST_OUT
	} bstate_t;

	typedef enum logic [1:0] {CTX_ADV, CTX_HEAL_NEXT, CTX_HEAL_ENTRY} ctx_t;

	bstate_t       state_q;
	ctx_t          ctx_q;
	cmd_t          cmd_q;
	logic [IW-1:0] idx_q, row_q, nidx_q, bidx_q;
	logic [SW-1:0] sc_q;
	logic [31:0]   rp_q, tgt_q, ld_q, best_q, mm_peer_q;
	logic          rf_q, acc_q, agree_q, fail_q, complete_q, have_q, mm_q;
	logic [2:0]    mm_seat_q;
	logic [SN-1:0] mrow_q;
	logic          lvalid_q [RING_DEPTH];
	logic          rvalid_q [RING_DEPTH];
	res_t          res_q;
	logic          ovalid_q;

	// ring storage
	logic [63:0]   lmem [RING_DEPTH];
	logic [SN-1:0] mmem [RING_DEPTH];
	logic [63:0]   smem [SN << IW];
	logic [63:0]   lrd, srd;
	logic [SN-1:0] mrd;

	logic [SN-1:0] expn, mrow_now, tbit;
	logic [SW-1:0] tsel;
	logic          peer_ok, lhit_cur, shit;
	logic [31:0]   lt, sd;
	logic          lwe, pwe;

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] x);
		wrap_inc = (x == LAST_ROW) ? '0 : x + 1'b1;
	endfunction

	// expected seat set
	always_comb begin
		for (int s = 0; s < SN; s++) begin
			if (s >= SEAT_COUNT || s >= 8)
				expn[s] = 1'b0;
			else if (cfg.multi)
				expn[s] = cfg.mask[s];
			else
				expn[s] = (s == 0);
		end
	end

	// peer target selection
	always_comb begin
		tsel    = cfg.multi ? SW'(cmd_q.seat) : '0;
		peer_ok = cfg.multi ?
			((32'(cmd_q.seat) < 32'(SEAT_COUNT)) && expn[SW'(cmd_q.seat)]) : expn[0];
		tbit       = '0;
		tbit[tsel] = 1'b1;
	end

	assign lt       = lrd[63:32];
	assign mrow_now = rvalid_q[row_q] ? mrd : '0;
	assign lhit_cur = lvalid_q[row_q] && (lt == tgt_q);
	assign sd       = srd[31:0];
	assign shit     = mrow_q[sc_q] && (srd[63:32] == tgt_q);
	assign lwe      = (state_q == ST_EXEC) && (cmd_q.op == OP_NOTE_LOCAL);
	assign pwe      = (state_q == ST_PWR);

	// memory ports: registered reads at the current row and seat
	always_ff @(posedge clk) begin
		if (lwe)
			lmem[idx_q] <= {cmd_q.tick, cmd_q.digest};
		if (pwe) begin
			mmem[row_q]         <= mrow_now | tbit;
			smem[{tsel, row_q}] <= {cmd_q.tick, cmd_q.digest};
		end
		lrd <= lmem[row_q];
		mrd <= mmem[row_q];
		srd <= smem[{sc_q, row_q}];
	end

	assign cmd_ready = (state_q == ST_IDLE);
	assign out_valid = ovalid_q;
	assign out_res   = res_q;

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rf_q     <= 1'b0;
			rp_q     <= '0;
			nidx_q   <= '0;
			ovalid_q <= 1'b0;
			for (int i = 0; i < RING_DEPTH; i++) begin
				lvalid_q[i] <= 1'b0;
				rvalid_q[i] <= 1'b0;
			end
		end else begin
			if (ovalid_q && out_ready && state_q != ST_OUT)
				ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd_in;
						idx_q   <= idx_in;
						acc_q   <= 1'b0;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_ADV;
					case (cmd_q.op)
						OP_NOTE_LOCAL: begin
							lvalid_q[idx_q] <= 1'b1;
							acc_q           <= 1'b1;
						end
						OP_NOTE_PEER: begin
							if (peer_ok) begin
								row_q   <= idx_q;
								state_q <= ST_PRD;
							end
						end
						OP_PRIME: begin
							for (int i = 0; i < RING_DEPTH; i++) begin
								lvalid_q[i] <= 1'b0;
								rvalid_q[i] <= 1'b0;
							end
							rp_q   <= cmd_q.tick;
							rf_q   <= 1'b1;
							nidx_q <= wrap_inc(idx_q);
						end
						OP_HEAL: begin
							if (rf_q && rp_q != TOP_TICK && expn != '0) begin
								ctx_q   <= CTX_HEAL_NEXT;
								row_q   <= nidx_q;
								tgt_q   <= rp_q + 32'd1;
								state_q <= ST_ROW;
							end
						end
						default: state_q <= ST_ADV;
					endcase
				end
				ST_PRD: state_q <= ST_PWR;
				ST_PWR: begin
					rvalid_q[row_q] <= 1'b1;
					acc_q           <= 1'b1;
					state_q         <= ST_ADV;
				end
				ST_ADV: begin
					mm_q  <= 1'b0;
					ctx_q <= CTX_ADV;
					if (!rf_q) begin
						tgt_q   <= '0;
						row_q   <= '0;
						state_q <= ST_ROW;
					end else if (rp_q == TOP_TICK) begin
						state_q <= ST_OUT;
					end else begin
						tgt_q   <= rp_q + 32'd1;
						row_q   <= nidx_q;
						state_q <= ST_ROW;
					end
				end
				ST_ROW: state_q <= ST_ROWD;
				ST_ROWD: begin
					mrow_q <= mrow_now;
					ld_q   <= lrd[31:0];
					sc_q   <= '0;
					fail_q <= 1'b0;
					case (ctx_q)
						CTX_ADV: begin
							agree_q <= (expn != '0);
							state_q <= lhit_cur ? ST_SEATI : ST_OUT;
						end
						CTX_HEAL_NEXT: begin
							state_q <= lhit_cur ? ST_ADV : ST_SEATI;
						end
						CTX_HEAL_ENTRY: begin
							complete_q <= 1'b1;
							if (lvalid_q[row_q] && lt > rp_q) begin
								tgt_q   <= lt;
								state_q <= ST_SEATI;
							end else begin
								state_q <= ST_HNEXT;
							end
						end
						default: state_q <= ST_OUT;
					endcase
				end
				ST_SEATI: begin
					if (expn[sc_q])
						state_q <= ST_SEATC;
					else if (sc_q == LAST_SEAT)
						state_q <= ST_ROWEND;
					else
						sc_q <= sc_q + 1'b1;
				end
				ST_SEATC: begin
					if (sc_q == LAST_SEAT)
						state_q <= ST_ROWEND;
					else begin
						sc_q    <= sc_q + 1'b1;
						state_q <= ST_SEATI;
					end
					case (ctx_q)
						CTX_ADV: begin
							if (!shit || sd != ld_q)
								agree_q <= 1'b0;
							if (shit && sd != ld_q && !mm_q) begin
								mm_q      <= 1'b1;
								mm_seat_q <= 3'(sc_q);
								mm_peer_q <= sd;
							end
						end
						CTX_HEAL_NEXT: begin
							if (shit)
								fail_q <= 1'b1;
						end
						CTX_HEAL_ENTRY: begin
							// contradicted later tick: abandon heal
							if (shit && sd != ld_q)
								state_q <= ST_ADV;
							if (!shit)
								complete_q <= 1'b0;
						end
						default: fail_q <= 1'b1;
					endcase
				end
				ST_ROWEND: begin
					case (ctx_q)
						CTX_ADV: begin
							if (agree_q) begin
								rp_q    <= tgt_q;
								rf_q    <= 1'b1;
								nidx_q  <= wrap_inc(row_q);
								state_q <= ST_ADV;
							end else begin
								state_q <= ST_OUT;
							end
						end
						CTX_HEAL_NEXT: begin
							if (fail_q) begin
								state_q <= ST_ADV;
							end else begin
								ctx_q   <= CTX_HEAL_ENTRY;
								row_q   <= '0;
								have_q  <= 1'b0;
								state_q <= ST_ROW;
							end
						end
						CTX_HEAL_ENTRY: begin
							if (complete_q && (!have_q || tgt_q > best_q)) begin
								best_q <= tgt_q;
								bidx_q <= row_q;
								have_q <= 1'b1;
							end
							state_q <= ST_HNEXT;
						end
						default: state_q <= ST_OUT;
					endcase
				end
				ST_HNEXT: begin
					if (row_q == LAST_ROW) begin
						if (have_q) begin
							rp_q   <= best_q;
							nidx_q <= wrap_inc(bidx_q);
							acc_q  <= 1'b1;
						end
						state_q <= ST_ADV;
					end else begin
						row_q   <= row_q + 1'b1;
						state_q <= ST_ROW;
					end
				end
				ST_OUT: begin
					if (!ovalid_q || out_ready) begin
						res_q.accepted       <= acc_q;
						res_q.resolved_ok    <= rf_q;
						res_q.resolved_tick  <= rf_q ? rp_q : '0;
						res_q.mismatch_found <= mm_q;
						res_q.mismatch_tick  <= mm_q ? tgt_q : '0;
						res_q.mismatch_seat  <= mm_q ? mm_seat_q : '0;
						res_q.mismatch_local <= mm_q ? ld_q : '0;
						res_q.mismatch_peer  <= mm_q ? mm_peer_q : '0;
						ovalid_q             <= 1'b1;
						state_q              <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/digest_agreement_tracker_core.sv @@
// Top level of the digest agreement tracker: stream ports, configuration
// registers, front end, queue and back end. Depends on dat_pkg and dat_* modules.
//
//  channel  | direction | payload
//  s_*      | in        | command item: opcode, seat, tick_number, digest_value
//  m_*      | out       | result item, one per command
//  cfg_*    | in        | register write: multi_seat_mode (0), seat_mask (1)
//
// Front: the low tick bits give the index for a power-of-two RING_DEPTH, else a
// reciprocal multiply, then a subtract. Back: a peer note adds a ring read and write;
// each examined tick reads its row, and when the local side holds it during an
// advance, every seat is visited, each expected seat compared and the row closed.
// A heal may walk all RING_DEPTH local entries, with a seat walk for each later one.
// Reset clears all valid bits at once; no clearing pass. Either side may stall.
`default_nettype none

module digest_agreement_tracker_core import dat_pkg::*; #(
	parameter int RING_DEPTH = DEF_RING_DEPTH,
	parameter int SEAT_COUNT = DEF_SEAT_COUNT
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// opcode[1:0], seat[9:2], tick_number[41:10], digest_value[73:42], zeros above
	input  wire logic [IN_BITS-1:0]  s_tdata,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// accepted[0], resolved_ok[1], resolved_tick[33:2], mismatch_found[34],
	// mismatch_tick[66:35], mismatch_seat[69:67], mismatch_local[101:70],
	// mismatch_peer[133:102], zeros above
	output logic [OUT_BITS-1:0]      m_tdata,
	input  wire logic                cfg_en,
	input  wire logic                cfg_index,
	input  wire logic [7:0]          cfg_data
);

	localparam int IW = $clog2(RING_DEPTH);
	localparam int QW = IW + $bits(cmd_t);

	cfg_t          cfg_q;
	cmd_t          in_cmd, f_cmd, b_cmd;
	logic [IW-1:0] f_idx, b_idx;
	logic          f_valid, f_ready, b_valid, b_ready;
	logic [QW-1:0] q_out;
	res_t          res;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_en) begin
			case (cfg_index)
				REG_MODE: cfg_q.multi <= cfg_data[0];
				REG_MASK: cfg_q.mask  <= cfg_data;
				default:  cfg_q       <= cfg_q;
			endcase
		end
	end

	// unpack input item
	assign in_cmd.op     = op_t'(s_tdata[1:0]);
	assign in_cmd.seat   = s_tdata[9:2];
	assign in_cmd.tick   = s_tdata[41:10];
	assign in_cmd.digest = s_tdata[73:42];

	dat_front #(.RING_DEPTH(RING_DEPTH), .IW(IW)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_cmd   (in_cmd),
		.q_valid  (f_valid),
		.q_ready  (f_ready),
		.q_cmd    (f_cmd),
		.q_idx    (f_idx)
	);

	dat_queue #(.W(QW)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  ({f_idx, f_cmd}),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_data  (q_out)
	);

	assign b_cmd = q_out[$bits(cmd_t)-1:0];
	assign b_idx = q_out[QW-1:$bits(cmd_t)];

	dat_back #(.RING_DEPTH(RING_DEPTH), .SEAT_COUNT(SEAT_COUNT), .IW(IW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (b_valid),
		.cmd_ready (b_ready),
		.cmd_in    (b_cmd),
		.idx_in    (b_idx),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	// pack result item
	assign m_tdata = {{(OUT_BITS - $bits(res_t)){1'b0}}, res};

endmodule

`default_nettype wire
